FILE: hw/rtl/stlb_pkg.sv
// stlb_pkg: sizes, request codes and entry/row types of the set-associative tlb
// no dependencies; used by stlb_set_logic and set_assoc_tlb_lru
`default_nettype none

package stlb_pkg;

    localparam int XLEN        = 64;
    localparam int OFFSET_BITS = 12;
    // power of two, at least two
    localparam int NUM_SETS    = 16;
    localparam int NUM_WAYS    = 4;
    localparam int ADDR_BITS   = 64;

    localparam int VPN_W = ADDR_BITS - OFFSET_BITS;
    localparam int PPN_W = XLEN - OFFSET_BITS;
    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int AGE_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int CUR_W = AGE_W + 1;
    localparam int REC_W = 3;

    localparam logic [1:0] REQ_XLATE = 2'd0;
    localparam logic [1:0] REQ_PEEK  = 2'd1;
    localparam logic [1:0] REQ_FLUSH = 2'd2;

    typedef struct packed {
        logic [VPN_W-1:0] tag;
        logic [PPN_W-1:0] ppn;
        logic [AGE_W-1:0] age;
    } entry_t;

    typedef entry_t [NUM_WAYS-1:0] row_t;

    localparam int ROW_W = $bits(row_t);

    typedef struct packed {
        logic                row_we;
        logic                vld_we;
        logic                flush;
        logic [NUM_WAYS-1:0] vld_row;
    } upd_t;

    typedef struct packed {
        logic [XLEN-1:0]  phys;
        logic             hit;
        logic             fault;
        logic [REC_W-1:0] recency;
    } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/stlb_ram.sv
// stlb_ram: generic one-write one-read ram with registered read data
// no dependencies; read during write to the same row returns the old row
`default_nettype none

module stlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/stlb_set_logic.sv
// stlb_set_logic: tag compare, lru victim choice and row update for one set
// depends on stlb_pkg
`default_nettype none

module stlb_set_logic (
    input  wire logic [1:0]                       req,
    input  wire logic [stlb_pkg::VPN_W-1:0]       vpn,
    input  wire logic [stlb_pkg::OFFSET_BITS-1:0] off,
    input  wire logic [stlb_pkg::PPN_W-1:0]       walk_ppn,
    input  wire logic                             walk_fault,
    input  wire stlb_pkg::row_t                   cur_row,
    input  wire logic [stlb_pkg::NUM_WAYS-1:0]    cur_vld,
    output stlb_pkg::row_t                        new_row,
    output stlb_pkg::upd_t                        upd,
    output stlb_pkg::res_t                        res
);

    import stlb_pkg::*;

    logic             hit_any;
    logic [WAY_W-1:0] hit_way;
    logic             inv_any;
    logic [WAY_W-1:0] inv_way;
    logic [WAY_W-1:0] old_way;
    logic [WAY_W-1:0] sel_way;
    logic [CUR_W-1:0] cur_age;
    row_t             touched;
    row_t             filled;

    // descending scans so the lowest matching way wins
    always_comb
    begin
        hit_any = 1'b0;
        hit_way = '0;
        inv_any = 1'b0;
        inv_way = '0;
        old_way = '0;
        for (int j = NUM_WAYS - 1; j >= 0; j--)
        begin
            if (cur_vld[j] && cur_row[j].tag == vpn)
            begin
                hit_any = 1'b1;
                hit_way = WAY_W'(j);
            end
            if (!cur_vld[j])
            begin
                inv_any = 1'b1;
                inv_way = WAY_W'(j);
            end
            // valid ages form a permutation, so the oldest way of a full set has the top age
            if (cur_row[j].age == AGE_W'(NUM_WAYS - 1))
            begin
                old_way = WAY_W'(j);
            end
        end
    end

    assign sel_way = hit_any ? hit_way : (inv_any ? inv_way : old_way);
    // an invalid way counts as older than every valid one
    assign cur_age = cur_vld[sel_way] ? {1'b0, cur_row[sel_way].age} : CUR_W'(NUM_WAYS);

    always_comb
    begin
        touched = cur_row;
        for (int j = 0; j < NUM_WAYS; j++)
        begin
            if (WAY_W'(j) == sel_way)
            begin
                touched[j].age = '0;
            end
            else if (cur_vld[j] && {1'b0, cur_row[j].age} < cur_age)
            begin
                touched[j].age = cur_row[j].age + AGE_W'(1);
            end
        end
        filled              = touched;
        filled[sel_way].tag = vpn;
        filled[sel_way].ppn = walk_ppn;
    end

    always_comb
    begin
        new_row     = touched;
        upd         = '0;
        res         = '0;
        unique case (req)
            REQ_XLATE:
            begin
                if (hit_any)
                begin
                    upd.row_we = 1'b1;
                    res.phys   = {cur_row[hit_way].ppn, off};
                    res.hit    = 1'b1;
                end
                else if (walk_fault)
                begin
                    res.phys  = '1;
                    res.fault = 1'b1;
                end
                else
                begin
                    new_row     = filled;
                    upd.row_we  = 1'b1;
                    upd.vld_we  = 1'b1;
                    upd.vld_row = cur_vld | (NUM_WAYS'(1) << sel_way);
                    res.phys    = {walk_ppn, off};
                end
            end
            REQ_PEEK:
            begin
                if (hit_any)
                begin
                    res.hit     = 1'b1;
                    res.recency = REC_W'(CUR_W'(NUM_WAYS) - {1'b0, cur_row[hit_way].age});
                end
            end
            REQ_FLUSH:
            begin
                upd.flush = 1'b1;
            end
            default:
            begin
                upd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/set_assoc_tlb_lru.sv
// set_assoc_tlb_lru: 4-way set-associative tlb with true lru, top level
// depends on stlb_pkg, stlb_ram, stlb_set_logic
//
//  channel   handshake            payload
//  request   start / busy         req_type, virt_addr, walk_page_addr, walk_fault
//  result    done (one cycle)     phys_addr, hit, fault, recency
//
// one transaction per cycle; busy stays low. request and row read are registered at
// accept; the result is then registered with done and taken at the end of the done cycle.
// tags, pages and ages sit in one ram row per set, read at accept and written back in the
// cycle after; a one-row bypass covers a set written on the edge that launched the read.
// reset clears the valid flags and done but not the ram, so requests are taken right away.
// results cannot be held off: each is on the ports for exactly the done cycle.
`default_nettype none

module set_assoc_tlb_lru (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [1:0]                req_type,
    input  wire logic [stlb_pkg::XLEN-1:0] virt_addr,
    input  wire logic [stlb_pkg::XLEN-1:0] walk_page_addr,
    input  wire logic                      walk_fault,
    output logic                           done,
    output logic [stlb_pkg::XLEN-1:0]      phys_addr,
    output logic                           hit,
    output logic                           fault,
    output logic [stlb_pkg::REC_W-1:0]     recency
);

    import stlb_pkg::*;

    logic                   accept;
    logic [VPN_W-1:0]       in_vpn;
    logic [SET_W-1:0]       in_set;

    logic                   s1_vld_reg;
    logic [1:0]             s1_req_reg;
    logic [VPN_W-1:0]       s1_vpn_reg;
    logic [OFFSET_BITS-1:0] s1_off_reg;
    logic [PPN_W-1:0]       s1_ppn_reg;
    logic                   s1_fault_reg;
    logic [SET_W-1:0]       s1_set;

    logic [NUM_WAYS-1:0]    vld_reg [NUM_SETS];
    logic [NUM_WAYS-1:0]    cur_vld;

    logic [ROW_W-1:0]       ram_rd;
    row_t                   cur_row;
    row_t                   new_row;
    upd_t                   upd;
    res_t                   res;
    logic                   row_we;

    logic                   byp_vld_reg;
    logic [SET_W-1:0]       byp_set_reg;
    row_t                   byp_row_reg;

    logic                   done_reg;
    res_t                   res_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign in_vpn = virt_addr[ADDR_BITS-1:OFFSET_BITS];
    assign in_set = in_vpn[SET_W-1:0];
    assign s1_set = s1_vpn_reg[SET_W-1:0];

    assign row_we  = s1_vld_reg && upd.row_we;
    assign cur_vld = vld_reg[s1_set];
    assign cur_row = (byp_vld_reg && byp_set_reg == s1_set) ? byp_row_reg : row_t'(ram_rd);

    stlb_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (s1_set),
        .wdata (new_row),
        .raddr (in_set),
        .rdata (ram_rd)
    );

    stlb_set_logic u_set_logic (
        .req        (s1_req_reg),
        .vpn        (s1_vpn_reg),
        .off        (s1_off_reg),
        .walk_ppn   (s1_ppn_reg),
        .walk_fault (s1_fault_reg),
        .cur_row    (cur_row),
        .cur_vld    (cur_vld),
        .new_row    (new_row),
        .upd        (upd),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            byp_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
            for (int s = 0; s < NUM_SETS; s++)
            begin
                vld_reg[s] <= '0;
            end
        end
        else
        begin
            s1_vld_reg  <= accept;
            byp_vld_reg <= row_we;
            done_reg    <= s1_vld_reg;
            if (s1_vld_reg && upd.flush)
            begin
                for (int s = 0; s < NUM_SETS; s++)
                begin
                    vld_reg[s] <= '0;
                end
            end
            else if (s1_vld_reg && upd.vld_we)
            begin
                vld_reg[s1_set] <= upd.vld_row;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg   <= req_type;
            s1_vpn_reg   <= in_vpn;
            s1_off_reg   <= virt_addr[OFFSET_BITS-1:0];
            s1_ppn_reg   <= walk_page_addr[XLEN-1:OFFSET_BITS];
            s1_fault_reg <= walk_fault;
        end
        byp_set_reg <= s1_set;
        byp_row_reg <= new_row;
        res_reg     <= res;
    end

    assign done      = done_reg;
    assign phys_addr = res_reg.phys;
    assign hit       = res_reg.hit;
    assign fault     = res_reg.fault;
    assign recency   = res_reg.recency;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 done)
        else $error("transaction accepted without a result two cycles later");

    a_hit_fault: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(hit && fault))
        else $error("hit and fault reported together");

    a_fault_ones: assert property (@(posedge clk) disable iff (!rst_n)
        done && fault |-> (phys_addr == '1 && recency == '0))
        else $error("fault result without all-ones address");

    a_recency_hit: assert property (@(posedge clk) disable iff (!rst_n)
        done && recency != '0 |-> hit)
        else $error("recency reported on a miss");

endmodule

`default_nettype wire

FILE: verif/tb_set_assoc_tlb_lru.sv
// tb_set_assoc_tlb_lru: self-checking testbench for the set-associative tlb with true lru
// depends on stlb_pkg and set_assoc_tlb_lru; keeps its own copy of tags, pages, valids and ages
`default_nettype none

module tb_set_assoc_tlb_lru;

    import stlb_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam logic [XLEN-1:0] ADDR_MASK = {XLEN{1'b1}} >> (XLEN - ADDR_BITS);
    localparam logic [XLEN-1:0] OFFSET_MASK =
        {{(XLEN-OFFSET_BITS){1'b0}}, {OFFSET_BITS{1'b1}}};
    localparam int HI_W = VPN_W - SET_W;
    localparam int POOL_SIZE = 20;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          req_type;
    logic [XLEN-1:0]     virt_addr;
    logic [XLEN-1:0]     walk_page_addr;
    logic                walk_fault;
    logic                done;
    logic [XLEN-1:0]     phys_addr;
    logic                hit;
    logic                fault;
    logic [REC_W-1:0]    recency;

    // shadow of the translation state
    logic [VPN_W-1:0]    shadow_tag   [NUM_SETS][NUM_WAYS];
    logic [XLEN-1:0]     shadow_page  [NUM_SETS][NUM_WAYS];
    logic                shadow_valid [NUM_SETS][NUM_WAYS];
    logic [AGE_W-1:0]    shadow_age   [NUM_SETS][NUM_WAYS];

    res_t                pending_results[$];
    int                  failures = 0;

    set_assoc_tlb_lru dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .virt_addr      (virt_addr),
        .walk_page_addr (walk_page_addr),
        .walk_fault     (walk_fault),
        .done           (done),
        .phys_addr      (phys_addr),
        .hit            (hit),
        .fault          (fault),
        .recency        (recency)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(400000 * 20);
        $display("status: fail");
        $finish;
    end

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("mismatch: %s", msg);
    endtask

    function automatic int find_way(input int set, input logic [VPN_W-1:0] vpn);
        for (int j = 0; j < NUM_WAYS; j++)
        begin
            if (shadow_valid[set][j] && shadow_tag[set][j] == vpn)
                return j;
        end
        return NUM_WAYS;
    endfunction

    // way becomes age 0; valid ways younger than its old age move back by one
    task automatic make_recent(input int set, input int way);
        int cur;
        cur = shadow_valid[set][way] ? int'(shadow_age[set][way]) : NUM_WAYS;
        for (int j = 0; j < NUM_WAYS; j++)
        begin
            if (j != way && shadow_valid[set][j] && int'(shadow_age[set][j]) < cur)
                shadow_age[set][j] = shadow_age[set][j] + 1'b1;
        end
        shadow_age[set][way] = '0;
    endtask

    task automatic predict_translation(input logic [1:0] rt, input logic [XLEN-1:0] va_in,
                                       input logic [XLEN-1:0] walk_in, input logic wf);
        logic [XLEN-1:0]        va;
        logic [XLEN-1:0]        page;
        logic [VPN_W-1:0]       vpn;
        logic [OFFSET_BITS-1:0] off;
        int                     set;
        int                     way;
        res_t                   r;
        va   = va_in & ADDR_MASK;
        page = walk_in & ~OFFSET_MASK;
        vpn  = va[ADDR_BITS-1:OFFSET_BITS];
        off  = va[OFFSET_BITS-1:0];
        set  = int'(vpn % NUM_SETS);
        r    = '0;
        case (rt)
            REQ_XLATE:
            begin
                way = find_way(set, vpn);
                if (way < NUM_WAYS)
                begin
                    make_recent(set, way);
                    r.phys = shadow_page[set][way] | off;
                    r.hit  = 1'b1;
                end
                else if (wf)
                begin
                    r.phys  = '1;
                    r.fault = 1'b1;
                end
                else
                begin
                    // first invalid way, else the oldest (lowest index on ties)
                    way = 0;
                    while (way < NUM_WAYS && shadow_valid[set][way])
                        way++;
                    if (way == NUM_WAYS)
                    begin
                        way = 0;
                        for (int j = 1; j < NUM_WAYS; j++)
                        begin
                            if (shadow_age[set][j] > shadow_age[set][way])
                                way = j;
                        end
                    end
                    make_recent(set, way);
                    shadow_tag[set][way]   = vpn;
                    shadow_page[set][way]  = page;
                    shadow_valid[set][way] = 1'b1;
                    r.phys = page | off;
                end
            end
            REQ_PEEK:
            begin
                way = find_way(set, vpn);
                if (way < NUM_WAYS)
                begin
                    r.hit     = 1'b1;
                    r.recency = REC_W'(NUM_WAYS - int'(shadow_age[set][way]));
                end
            end
            REQ_FLUSH:
            begin
                for (int s = 0; s < NUM_SETS; s++)
                begin
                    for (int j = 0; j < NUM_WAYS; j++)
                    begin
                        shadow_valid[s][j] = 1'b0;
                        shadow_age[s][j]   = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        pending_results.push_back(r);
    endtask

    // predict on accepted transactions, then check any result on the ports
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && start && !busy)
            predict_translation(req_type, virt_addr, walk_page_addr, walk_fault);
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                note_failure("result with no transaction outstanding");
            else
            begin
                want = pending_results.pop_front();
                if (phys_addr !== want.phys)
                    note_failure($sformatf("phys_addr exp %h got %h", want.phys, phys_addr));
                if (hit !== want.hit)
                    note_failure($sformatf("hit exp %b got %b", want.hit, hit));
                if (fault !== want.fault)
                    note_failure($sformatf("fault exp %b got %b", want.fault, fault));
                if (recency !== want.recency)
                    note_failure($sformatf("recency exp %0d got %0d", want.recency, recency));
            end
        end
    end

    task automatic send_req(input logic [1:0] rt, input logic [XLEN-1:0] va,
                            input logic [XLEN-1:0] walk, input logic wf);
        @(negedge clk);
        start          <= 1'b1;
        req_type       <= rt;
        virt_addr      <= va;
        walk_page_addr <= walk;
        walk_fault     <= wf;
        do
            @(posedge clk);
        while (busy);
    endtask

    // start low with junk on the request fields
    task automatic idle_gap(input int n);
        @(negedge clk);
        start          <= 1'b0;
        req_type       <= 2'($urandom);
        virt_addr      <= {$urandom, $urandom};
        walk_page_addr <= {$urandom, $urandom};
        walk_fault     <= 1'($urandom);
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [XLEN-1:0] make_va(input logic [HI_W-1:0] hi, input int set,
                                                input logic [OFFSET_BITS-1:0] off);
        return {hi, SET_W'(set), off};
    endfunction

    task automatic test_flush_on_empty();
        send_req(REQ_FLUSH, '0, '0, 1'b0);
        send_req(REQ_PEEK, make_va('h1234, 3, 'h10), '0, 1'b0);
        send_req(REQ_XLATE, make_va('h1234, 3, 'h10), {$urandom, $urandom}, 1'b1);
    endtask

    task automatic test_fill_and_hit();
        // walker answer carries stray offset bits, which must be dropped
        send_req(REQ_XLATE, make_va('h00abc, 2, 'h123), 64'h0000_7654_3210_0fff, 1'b0);
        send_req(REQ_XLATE, make_va('h00abc, 2, 'hfed), {$urandom, $urandom}, 1'b1);
        send_req(REQ_PEEK, make_va('h00abc, 2, 'h000), '0, 1'b0);
    endtask

    task automatic test_lru_replacement();
        for (int k = 1; k <= 4; k++)
            send_req(REQ_XLATE, make_va(HI_W'(k), 5, 'h0), {$urandom, $urandom}, 1'b0);
        // oldest way reports the lowest recency
        send_req(REQ_PEEK, make_va(HI_W'(1), 5, 'h0), '0, 1'b0);
        send_req(REQ_XLATE, make_va(HI_W'(1), 5, 'h44), '0, 1'b0);
        send_req(REQ_XLATE, make_va(HI_W'(9), 5, 'h0), {$urandom, $urandom}, 1'b0);
        send_req(REQ_XLATE, make_va(HI_W'(2), 5, 'h0), '0, 1'b1);
        send_req(REQ_PEEK, make_va(HI_W'(9), 5, 'h0), '0, 1'b0);
    endtask

    task automatic test_address_extremes();
        send_req(REQ_XLATE, '1, '1, 1'b0);
        send_req(REQ_XLATE, '1, '0, 1'b1);
        send_req(REQ_XLATE, '0, '0, 1'b0);
        send_req(REQ_PEEK, '0, '1, 1'b1);
        send_req(REQ_UNKNOWN, '1, '1, 1'b1);
        send_req(REQ_FLUSH, '1, '1, 1'b1);
        send_req(REQ_PEEK, '1, '0, 1'b0);
    endtask

    // a small pool of pages over set_span adjacent sets keeps hits and evictions frequent
    task automatic run_random_traffic(input int count, input bit with_gaps, input int set_span);
        logic [VPN_W-1:0] vpn_pool [POOL_SIZE];
        logic [1:0]       rt;
        logic [XLEN-1:0]  va;
        int               base_set;
        int               pick;
        base_set = $urandom_range(0, NUM_SETS - 1);
        foreach (vpn_pool[i])
        begin
            vpn_pool[i] = VPN_W'({$urandom, $urandom});
            vpn_pool[i][SET_W-1:0] = SET_W'((base_set + $urandom_range(0, set_span - 1))
                                            % NUM_SETS);
        end
        for (int k = 0; k < count; k++)
        begin
            if (with_gaps && $urandom_range(0, 7) == 0)
                idle_gap($urandom_range(1, 17));
            pick = $urandom_range(0, 99);
            if (pick < 62)
                rt = REQ_XLATE;
            else if (pick < 92)
                rt = REQ_PEEK;
            else if (pick < 94)
                rt = REQ_FLUSH;
            else
                rt = REQ_UNKNOWN;
            if ($urandom_range(0, 9) == 0)
                va = {$urandom, $urandom};
            else
                va = {vpn_pool[$urandom_range(0, POOL_SIZE - 1)], OFFSET_BITS'($urandom)};
            send_req(rt, va, {$urandom, $urandom}, $urandom_range(0, 99) < 15);
        end
    endtask

    task automatic test_random_traffic();
        run_random_traffic(300, 1'b1, 2);
        drain_results();
        run_random_traffic(250, 1'b1, NUM_SETS);
    endtask

    task automatic test_back_to_back();
        run_random_traffic(150, 1'b0, 3);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        req_type       = '0;
        virt_addr      = '0;
        walk_page_addr = '0;
        walk_fault     = 1'b0;
        for (int s = 0; s < NUM_SETS; s++)
        begin
            for (int j = 0; j < NUM_WAYS; j++)
            begin
                shadow_tag[s][j]   = '0;
                shadow_page[s][j]  = '0;
                shadow_valid[s][j] = 1'b0;
                shadow_age[s][j]   = '0;
            end
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_flush_on_empty();
        test_fill_and_hit();
        test_lru_replacement();
        test_address_extremes();
        test_random_traffic();
        test_back_to_back();

        drain_results();
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
